FILE: rtl/sop_cube_word_alu_core_defines.svh
// ----------------------------------------------------------------------------
// sop_cube_word_alu_core_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SOP_CUBE_WORD_ALU_CORE_DEFINES_SVH
`define SOP_CUBE_WORD_ALU_CORE_DEFINES_SVH

// same-cycle implication
`define SCW_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sop_cwa_pkg.sv
// ----------------------------------------------------------------------------
// sop_cwa_pkg
// types, codes and constants of the cube word alu
// ----------------------------------------------------------------------------
package sop_cwa_pkg;

    localparam int MAX_VARS_DEF  = 256;
    localparam int MAX_WORDS_DEF = 8;

    localparam int WORD_W = 64;
    localparam int VAR_W  = 8;
    localparam int PAIRS_PER_WORD_LOG = 5;

    localparam logic [WORD_W-1:0] ODD_MASK  = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] EVEN_MASK = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [WORD_W-1:0] PAIR_MASK = 64'd3;
    localparam logic [WORD_W-1:0] POS_LIT   = 64'd2;
    localparam logic [WORD_W-1:0] NEG_LIT   = 64'd1;

    typedef enum logic [2:0] {
        FUNC_PRODUCT     = 3'd0,
        FUNC_COFACTOR    = 3'd1,
        FUNC_COMPARE     = 3'd2,
        FUNC_NULL_CHECK  = 3'd3,
        FUNC_LIT_PRODUCT = 3'd4,
        FUNC_LIT_COFACT  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_GREATER = 2'd1,
        CMP_SMALLER = 2'd2
    } cmp_t;

    localparam logic [1:0] CMP_INVALID = 2'd3;

    typedef struct packed {
        logic [2:0]        func;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [VAR_W-1:0]  lit_var;
        logic              lit_negative;
        logic              last_word;
    } cmd_t;

    typedef struct packed {
        logic       conflict_seen;
        logic [1:0] order_decided;
        logic       nonzero_seen;
    } sticky_t;

    typedef struct packed {
        logic       status_valid;
        logic       success;
        logic [1:0] compare_result;
    } status_t;

    function automatic logic pair_conflict(input logic [WORD_W-1:0] w);
        return ((w & ODD_MASK) | ((w & EVEN_MASK) >> 1)) != ODD_MASK;
    endfunction

endpackage

FILE: rtl/sop_cwa_if.sv
// ----------------------------------------------------------------------------
// sop_cwa_if
// valid/ready channels for cube words in and result words out
// ----------------------------------------------------------------------------
interface sop_cwa_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [7:0]  lit_var;
    logic        lit_negative;
    logic        last_word;

    modport source (output valid, func, word_a, word_b, lit_var, lit_negative, last_word,
                    input ready);
    modport sink   (input valid, func, word_a, word_b, lit_var, lit_negative, last_word,
                    output ready);
endinterface

interface sop_cwa_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_out;
    logic        status_valid;
    logic        success;
    logic [1:0]  compare_result;

    modport source (output valid, word_out, status_valid, success, compare_result,
                    input ready);
    modport sink   (input valid, word_out, status_valid, success, compare_result,
                    output ready);
endinterface

FILE: rtl/sop_cube_word_alu_core.sv
// ----------------------------------------------------------------------------
// sop_cube_word_alu_core
// streaming cube operations in two-bit positional notation
// ----------------------------------------------------------------------------
// Takes one 64-bit cube word per cycle unless res.ready stalls, and returns
// one result word per item via an input register, then a result register.
// The sticky conflict, order and nonzero flags and the word position live
// next to the result register and are updated as each word moves into it,
// so words stream at one item per clock with no gap between cubes; status
// fields are valid only on the word marked last, after which all flags clear.
module sop_cube_word_alu_core #(
    parameter int MAX_VARS  = sop_cwa_pkg::MAX_VARS_DEF,
    parameter int MAX_WORDS = sop_cwa_pkg::MAX_WORDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sop_cwa_cmd_if.sink    cmd,
    sop_cwa_res_if.source  res
);
    localparam int POS_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic                  s1_valid_reg;
    sop_cwa_pkg::cmd_t     s1_cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    sop_cwa_pkg::sticky_t  sticky_reg;
    sop_cwa_pkg::sticky_t  sticky_next;
    logic                  res_valid_reg;
    logic [63:0]           res_word_reg;
    logic [63:0]           res_word_next;
    sop_cwa_pkg::status_t  res_status_reg;
    sop_cwa_pkg::status_t  res_status_next;
    sop_cwa_pkg::cmd_t     cmd_in;
    logic                  res_free;
    logic                  s1_adv;
    logic                  cmd_take;

    assign res_free = !res_valid_reg || res.ready;
    assign s1_adv   = s1_valid_reg && res_free;
    assign cmd.ready = !s1_valid_reg || res_free;
    assign cmd_take = cmd.valid && cmd.ready;

    assign cmd_in.func         = cmd.func;
    assign cmd_in.word_a       = cmd.word_a;
    assign cmd_in.word_b       = cmd.word_b;
    assign cmd_in.lit_var      = cmd.lit_var;
    assign cmd_in.lit_negative = cmd.lit_negative;
    assign cmd_in.last_word    = cmd.last_word;

    sop_cwa_word_op #(
        .MAX_VARS  (MAX_VARS),
        .MAX_WORDS (MAX_WORDS),
        .POS_W     (POS_W)
    ) u_word_op (
        .cmd         (s1_cmd_reg),
        .pos         (pos_reg),
        .sticky      (sticky_reg),
        .word_out    (res_word_next),
        .status      (res_status_next),
        .sticky_next (sticky_next),
        .pos_next    (pos_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sticky_reg    <= '0;
        end
        else
        begin
            if (cmd_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                sticky_reg    <= sticky_next;
            end
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            s1_cmd_reg <= cmd_in;
        if (s1_adv)
        begin
            res_word_reg   <= res_word_next;
            res_status_reg <= res_status_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.word_out       = res_word_reg;
    assign res.status_valid   = res_status_reg.status_valid;
    assign res.success        = res_status_reg.success;
    assign res.compare_result = res_status_reg.compare_result;

endmodule

FILE: rtl/sop_cwa_word_op.sv
// ----------------------------------------------------------------------------
// sop_cwa_word_op
// one cube word: result word, sticky flag update and last-word status
// ----------------------------------------------------------------------------
module sop_cwa_word_op #(
    parameter int MAX_VARS  = sop_cwa_pkg::MAX_VARS_DEF,
    parameter int MAX_WORDS = sop_cwa_pkg::MAX_WORDS_DEF,
    parameter int POS_W     = 3
) (
    input  sop_cwa_pkg::cmd_t      cmd,
    input  logic [POS_W-1:0]       pos,
    input  sop_cwa_pkg::sticky_t   sticky,
    output logic [63:0]            word_out,
    output sop_cwa_pkg::status_t   status,
    output sop_cwa_pkg::sticky_t   sticky_next,
    output logic [POS_W-1:0]       pos_next
);
    localparam int WIDX_W = sop_cwa_pkg::VAR_W - sop_cwa_pkg::PAIRS_PER_WORD_LOG;
    localparam int CMP_W  = (POS_W > WIDX_W) ? POS_W : WIDX_W;

    logic [5:0]         sft;
    logic [63:0]        pmask;
    logic [63:0]        lit_pat;
    logic [63:0]        opp_pat;
    logic [63:0]        prod;
    logic [63:0]        lit_word;
    logic               in_range;
    logic               hit;
    logic [CMP_W-1:0]   widx;
    logic [CMP_W-1:0]   pos_ext;
    sop_cwa_pkg::sticky_t upd;

    assign sft      = {cmd.lit_var[sop_cwa_pkg::PAIRS_PER_WORD_LOG-1:0], 1'b0};
    assign pmask    = sop_cwa_pkg::PAIR_MASK << sft;
    assign lit_pat  = (cmd.lit_negative ? sop_cwa_pkg::NEG_LIT : sop_cwa_pkg::POS_LIT) << sft;
    assign opp_pat  = (cmd.lit_negative ? sop_cwa_pkg::POS_LIT : sop_cwa_pkg::NEG_LIT) << sft;
    assign prod     = cmd.word_a & cmd.word_b;
    assign lit_word = cmd.word_a & (~pmask | lit_pat);
    assign in_range = 32'(cmd.lit_var) < 32'(MAX_VARS);
    assign widx     = CMP_W'(cmd.lit_var[sop_cwa_pkg::VAR_W-1:sop_cwa_pkg::PAIRS_PER_WORD_LOG]);
    assign pos_ext  = CMP_W'(pos);
    assign hit      = in_range && (widx == pos_ext);

    always_comb
    begin
        upd      = sticky;
        word_out = cmd.word_a;
        case (cmd.func)
            sop_cwa_pkg::FUNC_PRODUCT:
            begin
                word_out = prod;
                if (sop_cwa_pkg::pair_conflict(prod))
                    upd.conflict_seen = 1'b1;
            end
            sop_cwa_pkg::FUNC_COFACTOR:
            begin
                word_out = cmd.word_a | ~cmd.word_b;
                if (sop_cwa_pkg::pair_conflict(prod))
                    upd.conflict_seen = 1'b1;
            end
            sop_cwa_pkg::FUNC_COMPARE:
            begin
                word_out = '0;
                if (sticky.order_decided == sop_cwa_pkg::CMP_EQUAL)
                begin
                    if (cmd.word_a > cmd.word_b)
                        upd.order_decided = sop_cwa_pkg::CMP_GREATER;
                    else if (cmd.word_a < cmd.word_b)
                        upd.order_decided = sop_cwa_pkg::CMP_SMALLER;
                end
            end
            sop_cwa_pkg::FUNC_NULL_CHECK:
            begin
                word_out = '0;
                if (cmd.word_a != '0)
                    upd.nonzero_seen = 1'b1;
            end
            sop_cwa_pkg::FUNC_LIT_PRODUCT:
            begin
                if (hit)
                begin
                    word_out = lit_word;
                    if ((lit_word & pmask) == '0)
                        upd.conflict_seen = 1'b1;
                end
            end
            sop_cwa_pkg::FUNC_LIT_COFACT:
            begin
                if (hit)
                begin
                    word_out = cmd.word_a | pmask;
                    if ((cmd.word_a & pmask) == opp_pat)
                        upd.conflict_seen = 1'b1;
                end
            end
            default:
            begin
                word_out = cmd.word_a;
            end
        endcase
    end

    always_comb
    begin
        status = '0;
        if (cmd.last_word)
        begin
            status.status_valid = 1'b1;
            if (cmd.func == sop_cwa_pkg::FUNC_COMPARE)
            begin
                status.success        = 1'b1;
                status.compare_result = upd.order_decided;
            end
            else if (cmd.func == sop_cwa_pkg::FUNC_NULL_CHECK)
                status.success = !upd.nonzero_seen;
            else
                status.success = !upd.conflict_seen;
        end
    end

    always_comb
    begin
        if (cmd.last_word)
        begin
            sticky_next = '0;
            pos_next    = '0;
        end
        else
        begin
            sticky_next = upd;
            pos_next    = (pos == POS_W'(MAX_WORDS - 1)) ? '0 : pos + POS_W'(1);
        end
    end

endmodule

FILE: rtl/sop_cwa_checker.sv
// ----------------------------------------------------------------------------
// sop_cwa_checker
// port-level checks of the cube word alu, bound to the top level
// ----------------------------------------------------------------------------
`include "sop_cube_word_alu_core_defines.svh"

module sop_cwa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] res_word_out,
    input logic        res_status_valid,
    input logic        res_success,
    input logic [1:0]  res_compare_result
);
    logic res_stall;

    assign res_stall = res_valid && !res_ready;

    `SCW_ASSERT_NOW(a_status_quiet, clk, rst_n, res_valid && !res_status_valid, !res_success && (res_compare_result == sop_cwa_pkg::CMP_EQUAL), "status fields set off the last word")
    `SCW_ASSERT_NOW(a_cmp_code, clk, rst_n, res_valid, res_compare_result != sop_cwa_pkg::CMP_INVALID, "unused compare code")
    `SCW_ASSERT_NEXT(a_stall_valid, clk, rst_n, res_stall, res_valid, "result dropped while stalled")
    `SCW_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_stall, $stable(res_word_out) && $stable(res_status_valid) && $stable(res_success) && $stable(res_compare_result), "result changed while stalled")

endmodule

bind sop_cube_word_alu_core sop_cwa_checker u_sop_cwa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_word_out       (res.word_out),
    .res_status_valid   (res.status_valid),
    .res_success        (res.success),
    .res_compare_result (res.compare_result)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming cube word alu
// ----------------------------------------------------------------------------
// Streams cube words through the valid/ready channels. Each accepted item
// runs through a behavioral model of the pair arithmetic and the sticky
// conflict, order and nonzero flags. Every result word is checked field by
// field in order. A directed set of corner cubes comes first. Random cubes
// follow, mostly well-formed, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sop_cwa_pkg::*;

    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
    localparam int TOTAL_ITEMS = 900;
    localparam int QUIET_TAIL = 80;
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [63:0] ONES = '1;

    typedef struct {
        logic [2:0]  func;
        logic [63:0] word_a;
        logic [63:0] word_b;
        logic [7:0]  lit_var;
        logic        lit_negative;
        logic        last_word;
        bit          drain_first;
    } cube_word_t;

    typedef struct {
        logic [63:0] word_out;
        logic        status_valid;
        logic        success;
        logic [1:0]  compare_result;
    } cube_result_t;

    logic clk;
    logic rst_n;

    sop_cwa_cmd_if cmd ();
    sop_cwa_res_if res ();

    sop_cube_word_alu_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    cube_word_t   pending_words[$];
    cube_result_t expected_results[$];
    cube_word_t   in_flight;

    int          word_pos;
    logic        conflict_flag;
    logic [1:0]  order_flag;
    logic        nonzero_flag;

    int          accepted_count;
    int          checked_count;
    int          status_count;
    int          failed_status_count;
    int          fail_count;
    int          cycle_count;
    int          send_gap;
    int          recv_stall;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic has_void_pair(input logic [63:0] w);
        for (int i = 0; i < 32; i++)
        begin
            if (w[2*i +: 2] == 2'b00)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    // per pair: absent half the time, else one of the literals, rarely a void pair
    function automatic logic [63:0] clean_word(input int void_pm);
        logic [63:0] w;
        for (int i = 0; i < 32; i++)
        begin
            case ($urandom_range(3))
                0, 1: w[2*i +: 2] = 2'b11;
                2: w[2*i +: 2] = 2'b10;
                default: w[2*i +: 2] = 2'b01;
            endcase
            if ($urandom_range(999) < void_pm)
                w[2*i +: 2] = 2'b00;
        end
        return w;
    endfunction

    // second cube word that mostly agrees with the first
    function automatic logic [63:0] mate_word(input logic [63:0] a, input int clash_pct);
        logic [63:0] w;
        int r;
        for (int i = 0; i < 32; i++)
        begin
            r = $urandom_range(99);
            if (r < clash_pct)
                w[2*i +: 2] = ~a[2*i +: 2];
            else if (r < 60)
                w[2*i +: 2] = 2'b11;
            else
                w[2*i +: 2] = a[2*i +: 2];
        end
        return w;
    endfunction

    function automatic cube_result_t predict_cube_word(input cube_word_t it);
        cube_result_t r;
        logic [63:0] w;
        logic [63:0] pmask;
        logic [63:0] lit_pat;
        logic [63:0] opp_pat;
        int shift;
        logic hit;
        shift = 2 * (int'(it.lit_var) % 32);
        pmask = PAIR_MASK << shift;
        lit_pat = (it.lit_negative ? NEG_LIT : POS_LIT) << shift;
        opp_pat = (it.lit_negative ? POS_LIT : NEG_LIT) << shift;
        hit = (int'(it.lit_var) < MAX_VARS_DEF) && ((int'(it.lit_var) / 32) == word_pos);
        w = it.word_a;
        case (it.func)
            FUNC_PRODUCT:
            begin
                w = it.word_a & it.word_b;
                if (has_void_pair(w))
                    conflict_flag = 1'b1;
            end
            FUNC_COFACTOR:
            begin
                if (has_void_pair(it.word_a & it.word_b))
                    conflict_flag = 1'b1;
                w = it.word_a | ~it.word_b;
            end
            FUNC_COMPARE:
            begin
                w = '0;
                if (order_flag == CMP_EQUAL)
                begin
                    if (it.word_a > it.word_b)
                        order_flag = CMP_GREATER;
                    else if (it.word_a < it.word_b)
                        order_flag = CMP_SMALLER;
                end
            end
            FUNC_NULL_CHECK:
            begin
                w = '0;
                if (it.word_a != '0)
                    nonzero_flag = 1'b1;
            end
            FUNC_LIT_PRODUCT:
            begin
                if (hit)
                begin
                    w = it.word_a & (~pmask | lit_pat);
                    if ((w & pmask) == '0)
                        conflict_flag = 1'b1;
                end
            end
            FUNC_LIT_COFACT:
            begin
                if (hit)
                begin
                    if ((it.word_a & pmask) == opp_pat)
                        conflict_flag = 1'b1;
                    w = it.word_a | pmask;
                end
            end
            default: ;
        endcase
        r.word_out = w;
        if (it.last_word)
        begin
            r.status_valid = 1'b1;
            if (it.func == FUNC_COMPARE)
                r.success = 1'b1;
            else if (it.func == FUNC_NULL_CHECK)
                r.success = ~nonzero_flag;
            else
                r.success = ~conflict_flag;
            r.compare_result = (it.func == FUNC_COMPARE) ? order_flag : CMP_EQUAL;
            word_pos = 0;
            conflict_flag = 1'b0;
            order_flag = CMP_EQUAL;
            nonzero_flag = 1'b0;
        end
        else
        begin
            r.status_valid = 1'b0;
            r.success = 1'b0;
            r.compare_result = CMP_EQUAL;
            word_pos = (word_pos + 1 >= MAX_WORDS_DEF) ? 0 : word_pos + 1;
        end
        return r;
    endfunction

    function automatic bit idle_allowed();
        return (pending_words.size() >= QUIET_TAIL) && (((accepted_count / 64) % 4) != 3);
    endfunction

    task automatic add_word(input logic [2:0] func, input logic [63:0] a, input logic [63:0] b,
                            input logic [7:0] lit_var, input logic neg, input logic last,
                            input bit drain);
        cube_word_t it;
        it.func = func;
        it.word_a = a;
        it.word_b = b;
        it.lit_var = lit_var;
        it.lit_negative = neg;
        it.last_word = last;
        it.drain_first = drain;
        pending_words.push_back(it);
    endtask

    task automatic add_random_cube(input bit drain);
        logic [2:0] op;
        logic [2:0] word_op;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0] var_idx;
        logic neg;
        int n_words;
        int kind;
        int diff_at;
        int clash_pct;
        int void_pm;
        kind = $urandom_range(99);
        case ($urandom_range(5))
            0: op = FUNC_PRODUCT;
            1: op = FUNC_COFACTOR;
            2: op = FUNC_COMPARE;
            3: op = FUNC_NULL_CHECK;
            4: op = FUNC_LIT_PRODUCT;
            default: op = FUNC_LIT_COFACT;
        endcase
        var_idx = 8'($urandom_range(255));
        neg = 1'($urandom_range(1));
        clash_pct = ($urandom_range(1) == 1) ? 0 : $urandom_range(1, 4);
        void_pm = ($urandom_range(9) == 0) ? 20 : 0;
        if ((op == FUNC_LIT_PRODUCT || op == FUNC_LIT_COFACT) && $urandom_range(9) < 7)
            n_words = MAX_WORDS_DEF;
        else if ($urandom_range(9) == 0)
            n_words = $urandom_range(MAX_WORDS_DEF + 1, MAX_WORDS_DEF + 4);
        else
            n_words = $urandom_range(1, MAX_WORDS_DEF);
        diff_at = $urandom_range(n_words);
        for (int i = 0; i < n_words; i++)
        begin
            word_op = op;
            a = clean_word(void_pm);
            b = mate_word(a, clash_pct);
            case (op)
                FUNC_COMPARE:
                begin
                    b = a;
                    if (i >= diff_at)
                        b = ($urandom_range(1) == 1) ? a ^ (64'd1 << $urandom_range(63))
                                                     : random64();
                end
                FUNC_NULL_CHECK:
                    a = (i == diff_at) ? (64'd1 << $urandom_range(63)) : '0;
                default: ;
            endcase
            // noise: raw words, any code per word
            if (kind >= 88)
            begin
                word_op = 3'($urandom_range(7));
                a = random64();
                b = random64();
                var_idx = 8'($urandom_range(255));
            end
            add_word(word_op, a, b, var_idx, neg, i == n_words - 1, drain && i == 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_results.push_back(predict_cube_word(in_flight));
                accepted_count++;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd.valid <= 1'b0;
                end
                else if (pending_words.size() == 0 ||
                         (pending_words[0].drain_first && expected_results.size() != 0))
                    cmd.valid <= 1'b0;
                else if (idle_allowed() && $urandom_range(99) < 8)
                begin
                    send_gap = $urandom_range(4);
                    cmd.valid <= 1'b0;
                end
                else
                begin
                    in_flight = pending_words.pop_front();
                    cmd.func <= in_flight.func;
                    cmd.word_a <= in_flight.word_a;
                    cmd.word_b <= in_flight.word_b;
                    cmd.lit_var <= in_flight.lit_var;
                    cmd.lit_negative <= in_flight.lit_negative;
                    cmd.last_word <= in_flight.last_word;
                    cmd.valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no input item waiting: word_out %h", res.word_out);
                    fail_count++;
                end
                else
                begin
                    cube_result_t want;
                    want = expected_results.pop_front();
                    checked_count++;
                    if (res.word_out !== want.word_out)
                    begin
                        $error("word_out: expected %h, got %h", want.word_out, res.word_out);
                        fail_count++;
                    end
                    if (res.status_valid !== want.status_valid)
                    begin
                        $error("status_valid: expected %b, got %b",
                               want.status_valid, res.status_valid);
                        fail_count++;
                    end
                    if (res.success !== want.success)
                    begin
                        $error("success: expected %b, got %b", want.success, res.success);
                        fail_count++;
                    end
                    if (res.compare_result !== want.compare_result)
                    begin
                        $error("compare_result: expected %0d, got %0d",
                               want.compare_result, res.compare_result);
                        fail_count++;
                    end
                    if (want.status_valid)
                    begin
                        status_count++;
                        if (!want.success)
                            failed_status_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                res.ready <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(99) < 10)
            begin
                recv_stall = $urandom_range(4);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int cube_count;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.func = FUNC_PRODUCT;
        cmd.word_a = '0;
        cmd.word_b = '0;
        cmd.lit_var = '0;
        cmd.lit_negative = 1'b0;
        cmd.last_word = 1'b0;
        res.ready = 1'b0;
        word_pos = 0;
        conflict_flag = 1'b0;
        order_flag = CMP_EQUAL;
        nonzero_flag = 1'b0;
        accepted_count = 0;
        checked_count = 0;
        status_count = 0;
        failed_status_count = 0;
        fail_count = 0;
        cycle_count = 0;
        cube_count = 0;

        // products: clean, conflict then a word after it
        add_word(FUNC_PRODUCT, ONES, ONES, 8'd0, 1'b0, 1'b1, 1'b0);
        add_word(FUNC_PRODUCT, ONES, '0, 8'd0, 1'b0, 1'b0, 1'b0);
        add_word(FUNC_PRODUCT, ONES, ODD_MASK, 8'd0, 1'b0, 1'b1, 1'b0);
        // cofactor by a disjoint cube
        add_word(FUNC_COFACTOR, ODD_MASK, EVEN_MASK, 8'd0, 1'b0, 1'b1, 1'b0);
        // compare: equal, smaller decides, later greater word ignored
        add_word(FUNC_COMPARE, 64'd5, 64'd5, 8'd0, 1'b0, 1'b0, 1'b0);
        add_word(FUNC_COMPARE, 64'd3, ONES, 8'd0, 1'b0, 1'b0, 1'b0);
        add_word(FUNC_COMPARE, ONES, '0, 8'd0, 1'b0, 1'b1, 1'b0);
        add_word(FUNC_COMPARE, ONES, ONES - 64'd1, 8'd0, 1'b0, 1'b1, 1'b0);
        // null check: all zero, then top bit set
        add_word(FUNC_NULL_CHECK, '0, ONES, 8'd0, 1'b0, 1'b1, 1'b0);
        add_word(FUNC_NULL_CHECK, 64'h8000_0000_0000_0000, '0, 8'd0, 1'b0, 1'b1, 1'b0);
        // literal product: lowest variable, then opposite literal in word 1
        add_word(FUNC_LIT_PRODUCT, ONES, '0, 8'd0, 1'b0, 1'b1, 1'b0);
        add_word(FUNC_LIT_PRODUCT, ONES, '0, 8'd33, 1'b1, 1'b0, 1'b0);
        add_word(FUNC_LIT_PRODUCT, ONES & ~64'h4, '0, 8'd33, 1'b1, 1'b1, 1'b0);
        // literal cofactor on the top variable, cube longer than the word limit
        for (int i = 0; i <= MAX_WORDS_DEF; i++)
            add_word(FUNC_LIT_COFACT, (i == MAX_WORDS_DEF - 1) ? ONES & ~(64'd1 << 62) : ONES,
                     '0, 8'd255, 1'b1, i == MAX_WORDS_DEF, 1'b0);
        // unused codes, mixed within one cube
        add_word(FUNC_SPARE_6, 64'h0123_4567_89AB_CDEF, ONES, 8'd0, 1'b0, 1'b0, 1'b0);
        add_word(FUNC_SPARE_7, 64'hFEDC_BA98_7654_3210, '0, 8'd0, 1'b0, 1'b1, 1'b0);

        while (pending_words.size() < TOTAL_ITEMS)
        begin
            add_random_cube(cube_count % 150 == 0);
            cube_count++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || cmd.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d result items checked, %0d cubes closed with status, %0d reporting failure",
                 checked_count, status_count, failed_status_count);
        $display("covered all six operations, unused codes, word wrap and random cubes");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sop_cwa_pkg.sv
rtl/sop_cwa_if.sv
rtl/sop_cwa_word_op.sv
rtl/sop_cube_word_alu_core.sv
rtl/sop_cwa_checker.sv
verif/testbench.sv
